[rtl/lprh_pkg.sv]
// Package with the shared types, constants and codes of the reverse hash.
`timescale 1ns / 1ps
package lprh_pkg;
  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned KeyDepth = 1024;
  localparam int unsigned KeyW = 64;
  localparam int unsigned IdxW = 10;
  localparam int unsigned SizeW = 11;
  localparam int unsigned HashShift = 6;
  localparam logic [SizeW-1:0] SizeReset = 11'd1024;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [KeyW-1:0] object_key;
    logic [IdxW-1:0] entry_index;
  } req_t;

  typedef struct packed {
    logic found;
    logic [IdxW-1:0] result_index;
    logic error;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic [KeyW-1:0] dividend;
  } mod_req_t;
endpackage

[rtl/lprh_mod.sv]
// Bit-serial remainder unit: computes (key >> 6) mod size, one bit a cycle.
`timescale 1ns / 1ps
module lprh_mod #(
  parameter int unsigned SlotW = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  lprh_pkg::mod_req_t req_i,
  input  logic [SlotW:0] size_i,
  output logic busy_o,
  output logic done_o,
  output logic [SlotW-1:0] rem_o
);
  localparam int unsigned DivW = lprh_pkg::KeyW - lprh_pkg::HashShift;
  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0] quo_q, quo_d;
  logic [SlotW:0] rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [SlotW+1:0] trial;

  assign trial = {rem_q, quo_q[DivW-1]} - {1'b0, size_i};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d = req_i.dividend[lprh_pkg::KeyW-1:lprh_pkg::HashShift];
      rem_d = '0;
      cnt_d = CntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DivW-2:0], 1'b0};
      if (!trial[SlotW+1]) begin
        rem_d = trial[SlotW:0];
      end else begin
        rem_d = {rem_q[SlotW-1:0], quo_q[DivW-1]};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o = rem_q[SlotW-1:0];
endmodule

[rtl/linear_probe_reverse_hash.sv]
// Top level of the reverse hash from an object key to an entry index.
`timescale 1ns / 1ps
// The block maps a 64-bit object key to a 10-bit entry index through an open-addressed
// table with linear probing. Each item is handled alone: a bit-serial unit computes the
// home-slot remainder, then every probe reads the slot memory, and on a lookup it also
// reads the key memory. A delete then runs a back-shift that, for each occupied slot
// after the hole, reads the slot and key memories and computes the remainder of the key
// found there. After reset the slot memory is cleared one entry a cycle, and no item is
// accepted until the clear is done.
module linear_probe_reverse_hash #(
  parameter int unsigned TABLE_DEPTH = lprh_pkg::TableDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  lprh_pkg::req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output lprh_pkg::rsp_t out_data_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [lprh_pkg::SizeW-1:0] cfg_data_i
);
  localparam int unsigned SlotW = $clog2(TABLE_DEPTH);
  localparam int unsigned IdxW = lprh_pkg::IdxW;
  localparam int unsigned KeyW = lprh_pkg::KeyW;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_HASH = 4'd2;
  localparam logic [3:0] S_RDSLOT = 4'd3;
  localparam logic [3:0] S_SLOT = 4'd4;
  localparam logic [3:0] S_KEY = 4'd5;
  localparam logic [3:0] S_DNEXT = 4'd6;
  localparam logic [3:0] S_DSLOT = 4'd7;
  localparam logic [3:0] S_DKEY = 4'd8;
  localparam logic [3:0] S_DHASH = 4'd9;
  localparam logic [3:0] S_OUT = 4'd10;

  logic [IdxW-1:0] slot_mem [TABLE_DEPTH];
  logic [KeyW-1:0] key_mem [lprh_pkg::KeyDepth];

  logic [3:0] st_q, st_d;
  logic [lprh_pkg::SizeW-1:0] size_reg_q;
  logic [SlotW:0] eff_size;
  lprh_pkg::req_t req_q, req_d;
  lprh_pkg::rsp_t rsp_q, rsp_d;
  logic out_valid_q, out_valid_d;
  logic [SlotW-1:0] pos_q, pos_d, hole_q, hole_d;
  logic [SlotW:0] n_q, n_d;
  logic [IdxW-1:0] cur_q, cur_d;

  logic slot_we;
  logic [SlotW-1:0] slot_addr, slot_waddr;
  logic [IdxW-1:0] slot_wdata, slot_rdata;
  logic key_we;
  logic [IdxW-1:0] key_addr;
  logic [KeyW-1:0] key_rdata;

  lprh_pkg::mod_req_t mod_req;
  logic mod_busy, mod_done;
  logic [SlotW-1:0] mod_rem;

  logic [SlotW-1:0] pos_next;
  logic [SlotW:0] pos_ext;
  logic in_win;

  always_comb begin
    if (size_reg_q < lprh_pkg::SizeW'(2)) begin
      eff_size = (SlotW+1)'(2);
    end else if ({{(SlotW+1){1'b0}}, size_reg_q} >
                 (SlotW+lprh_pkg::SizeW+1)'(TABLE_DEPTH)) begin
      eff_size = (SlotW+1)'(TABLE_DEPTH);
    end else begin
      eff_size = (SlotW+1)'(size_reg_q);
    end
  end

  assign pos_ext = {1'b0, pos_q} + 1'b1;
  assign pos_next = (pos_ext >= eff_size) ? '0 : pos_ext[SlotW-1:0];

  // The entry at d moves into the hole unless its home t lies cyclically in (hole, d].
  always_comb begin
    if (pos_q < hole_q) begin
      in_win = (pos_q < mod_rem) && (mod_rem <= hole_q);
    end else begin
      in_win = (pos_q < mod_rem) || (mod_rem <= hole_q);
    end
  end

  lprh_mod #(.SlotW(SlotW)) u_mod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mod_req),
    .size_i(eff_size),
    .busy_o(mod_busy),
    .done_o(mod_done),
    .rem_o (mod_rem)
  );

  assign in_ready_o = (st_q == S_IDLE) && !out_valid_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o = rsp_q;

  always_comb begin
    st_d = st_q;
    req_d = req_q;
    rsp_d = rsp_q;
    out_valid_d = out_valid_q;
    pos_d = pos_q;
    hole_d = hole_q;
    n_d = n_q;
    cur_d = cur_q;
    slot_we = 1'b0;
    slot_addr = pos_q;
    slot_waddr = pos_q;
    slot_wdata = '0;
    key_we = 1'b0;
    key_addr = slot_rdata;
    mod_req.start = 1'b0;
    mod_req.dividend = req_q.object_key;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (st_q)
      S_CLEAR: begin
        slot_we = 1'b1;
        if (pos_q == SlotW'(TABLE_DEPTH - 1)) begin
          st_d = S_IDLE;
        end
        pos_d = pos_q + 1'b1;
      end
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          req_d = in_data_i;
          rsp_d = '0;
          n_d = '0;
          if (in_data_i.object_key == '0) begin
            rsp_d.error = (in_data_i.opcode != lprh_pkg::OP_LOOKUP);
            st_d = S_OUT;
          end else if (in_data_i.opcode == lprh_pkg::OP_UNUSED ||
                       (in_data_i.opcode != lprh_pkg::OP_LOOKUP &&
                        in_data_i.entry_index == '0)) begin
            rsp_d.error = 1'b1;
            st_d = S_OUT;
          end else begin
            mod_req.start = 1'b1;
            mod_req.dividend = in_data_i.object_key;
            st_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (mod_done) begin
          pos_d = mod_rem;
          st_d = S_RDSLOT;
        end
      end
      S_RDSLOT: begin
        if (n_q >= eff_size) begin
          rsp_d.error = (req_q.opcode != lprh_pkg::OP_LOOKUP);
          st_d = S_OUT;
        end else begin
          slot_addr = pos_q;
          st_d = S_SLOT;
        end
      end
      S_SLOT: begin
        cur_d = slot_rdata;
        key_addr = slot_rdata;
        priority if (req_q.opcode == lprh_pkg::OP_LOOKUP) begin
          if (slot_rdata == '0) begin
            st_d = S_OUT;
          end else begin
            st_d = S_KEY;
          end
        end else if (req_q.opcode == lprh_pkg::OP_INSERT) begin
          if (slot_rdata == '0) begin
            slot_we = 1'b1;
            slot_wdata = req_q.entry_index;
            key_we = 1'b1;
            key_addr = req_q.entry_index;
            rsp_d.found = 1'b1;
            st_d = S_OUT;
          end else begin
            pos_d = pos_next;
            n_d = n_q + 1'b1;
            st_d = S_RDSLOT;
          end
        end else begin
          if (slot_rdata == req_q.entry_index) begin
            hole_d = pos_q;
            n_d = '0;
            rsp_d.found = 1'b1;
            st_d = S_DNEXT;
          end else begin
            pos_d = pos_next;
            n_d = n_q + 1'b1;
            st_d = S_RDSLOT;
          end
        end
      end
      S_KEY: begin
        if (key_rdata == req_q.object_key) begin
          rsp_d.found = 1'b1;
          rsp_d.result_index = cur_q;
          st_d = S_OUT;
        end else begin
          pos_d = pos_next;
          n_d = n_q + 1'b1;
          st_d = S_RDSLOT;
        end
      end
      S_DNEXT: begin
        pos_d = pos_next;
        n_d = n_q + 1'b1;
        if (n_q + 1'b1 >= eff_size) begin
          slot_we = 1'b1;
          slot_waddr = hole_q;
          slot_wdata = '0;
          st_d = S_OUT;
        end else begin
          slot_addr = pos_next;
          st_d = S_DSLOT;
        end
      end
      S_DSLOT: begin
        cur_d = slot_rdata;
        key_addr = slot_rdata;
        if (slot_rdata == '0) begin
          slot_we = 1'b1;
          slot_waddr = hole_q;
          slot_wdata = '0;
          st_d = S_OUT;
        end else begin
          st_d = S_DKEY;
        end
      end
      S_DKEY: begin
        mod_req.start = 1'b1;
        mod_req.dividend = key_rdata;
        st_d = S_DHASH;
      end
      S_DHASH: begin
        if (mod_done) begin
          if (in_win) begin
            slot_we = 1'b1;
            slot_waddr = hole_q;
            slot_wdata = cur_q;
            hole_d = pos_q;
          end
          st_d = S_DNEXT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rdata <= slot_mem[slot_addr];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_addr] <= req_q.object_key;
    end
    key_rdata <= key_mem[key_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLEAR;
      pos_q <= '0;
      out_valid_q <= 1'b0;
      size_reg_q <= lprh_pkg::SizeReset;
    end else begin
      st_q <= st_d;
      pos_q <= pos_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        size_reg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
    hole_q <= hole_d;
    n_q <= n_d;
    cur_q <= cur_d;
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (st_q == S_IDLE)) else $error("ready outside idle");
  a_found_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.found && out_data_o.error)) else $error("found and error");
  a_idx_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.result_index != '0) |-> out_data_o.found)
    else $error("index without hit");
  a_mod_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_req.start |-> !mod_busy) else $error("remainder restarted while busy");
`endif
endmodule

[sim/tb_linear_probe_reverse_hash.sv]
// Testbench for the reverse hash: directed and random items checked against a predictor.
`timescale 1ns / 1ps
module tb_linear_probe_reverse_hash;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lprh_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lprh_pkg::rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lprh_pkg::SizeW-1:0] cfg_data = '0;

  linear_probe_reverse_hash dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [lprh_pkg::IdxW-1:0] slot_mem [lprh_pkg::TableDepthDef];
  logic [lprh_pkg::KeyW-1:0] key_mem [lprh_pkg::KeyDepth];
  int unsigned size_reg = lprh_pkg::SizeReset;
  lprh_pkg::rsp_t expected_rsps [$];
  logic [lprh_pkg::KeyW-1:0] live_keys [$];
  logic [lprh_pkg::IdxW-1:0] live_idx [$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_sizes = 0;
  bit no_gaps = 0;
  int hold_off = 0;
  int wait_left = 0;

  function automatic int unsigned active_size();
    int unsigned s;
    s = size_reg;
    if (s < 2) s = 2;
    if (s > lprh_pkg::TableDepthDef) s = lprh_pkg::TableDepthDef;
    return s;
  endfunction

  function automatic int unsigned home_of(logic [lprh_pkg::KeyW-1:0] key, int unsigned s);
    return int'((key >> lprh_pkg::HashShift) % 64'(s));
  endfunction

  function automatic int unsigned step_slot(int unsigned i, int unsigned s);
    return (i + 1 >= s) ? 0 : i + 1;
  endfunction

  function automatic void close_hole(int unsigned hole, int unsigned s);
    int unsigned d, steps, t;
    logic [lprh_pkg::IdxW-1:0] v;
    d = hole;
    steps = 0;
    v = 1;
    while (v != 0) begin
      forever begin
        d = step_slot(d, s);
        steps++;
        if (steps >= s) begin
          v = 0;
          break;
        end
        v = slot_mem[d];
        if (v == 0) break;
        t = home_of(key_mem[v], s);
        if ((d < hole) ? ((d < t) && (t <= hole)) : ((d < t) || (t <= hole))) break;
      end
      slot_mem[hole] = v;
      hole = d;
    end
  endfunction

  function automatic lprh_pkg::rsp_t hash_result(lprh_pkg::req_t r);
    lprh_pkg::rsp_t o;
    int unsigned s, h;
    logic [lprh_pkg::IdxW-1:0] v;
    o = '0;
    s = active_size();
    h = home_of(r.object_key, s);
    if (lprh_pkg::opcode_e'(r.opcode) == lprh_pkg::OP_LOOKUP) begin
      if (r.object_key != 0) begin
        for (int unsigned n = 0; n < s; n++) begin
          v = slot_mem[h];
          if (v == 0) break;
          if (key_mem[v] == r.object_key) begin
            o.found = 1'b1;
            o.result_index = v;
            break;
          end
          h = step_slot(h, s);
        end
      end
    end else if (lprh_pkg::opcode_e'(r.opcode) == lprh_pkg::OP_UNUSED ||
                 r.object_key == 0 || r.entry_index == 0) begin
      o.error = 1'b1;
    end else begin
      o.error = 1'b1;
      for (int unsigned n = 0; n < s; n++) begin
        if (lprh_pkg::opcode_e'(r.opcode) == lprh_pkg::OP_INSERT && slot_mem[h] == 0) begin
          key_mem[r.entry_index] = r.object_key;
          slot_mem[h] = r.entry_index;
          o.error = 1'b0;
        end else if (lprh_pkg::opcode_e'(r.opcode) == lprh_pkg::OP_DELETE &&
                     slot_mem[h] == r.entry_index) begin
          close_hole(h, s);
          o.error = 1'b0;
        end
        if (!o.error) break;
        h = step_slot(h, s);
      end
      o.found = !o.error;
    end
    return o;
  endfunction

  task automatic send_item(lprh_pkg::opcode_e op, logic [lprh_pkg::KeyW-1:0] key,
                           logic [lprh_pkg::IdxW-1:0] idx);
    int gap;
    lprh_pkg::req_t r;
    r.opcode = op;
    r.object_key = key;
    r.entry_index = idx;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk_i); while (!in_ready);
    expected_rsps.push_back(hash_result(r));
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_size(int unsigned value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= lprh_pkg::SizeW'(value);
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg = value & 32'h7FF;
    n_sizes++;
    live_keys.delete();
    live_idx.delete();
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid && out_ready) begin
        n_checked++;
        wait_left = no_gaps ? 0 : $urandom_range(0, 7);
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors++;
        end else begin
          lprh_pkg::rsp_t e;
          e = expected_rsps.pop_front();
          if (out_data.found !== e.found || out_data.result_index !== e.result_index ||
              out_data.error !== e.error) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, e, out_data);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [lprh_pkg::KeyW-1:0] near_key();
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom} | 64'h40;
    return (64'($urandom_range(0, 40)) << lprh_pkg::HashShift) |
           64'($urandom_range(0, 63)) | (64'($urandom_range(0, 1)) << 63);
  endfunction

  task automatic test_directed();
    send_item(lprh_pkg::OP_LOOKUP, 64'h0, 10'h3FF);
    send_item(lprh_pkg::OP_INSERT, 64'h0, 10'd5);
    send_item(lprh_pkg::OP_INSERT, 64'h1234_0040, 10'd0);
    send_item(lprh_pkg::OP_DELETE, 64'h0, 10'd5);
    send_item(lprh_pkg::OP_DELETE, 64'h1234_0040, 10'd0);
    send_item(lprh_pkg::OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF);
    send_item(lprh_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF);
    send_item(lprh_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0);
    send_item(lprh_pkg::OP_INSERT, 64'h40, 10'd1);
    send_item(lprh_pkg::OP_INSERT, 64'h7F, 10'd2);
    send_item(lprh_pkg::OP_INSERT, 64'h80, 10'd3);
    send_item(lprh_pkg::OP_LOOKUP, 64'h7F, 10'd0);
    send_item(lprh_pkg::OP_DELETE, 64'h40, 10'd9);
    send_item(lprh_pkg::OP_DELETE, 64'h40, 10'd1);
    send_item(lprh_pkg::OP_LOOKUP, 64'h80, 10'd0);
    send_item(lprh_pkg::OP_LOOKUP, 64'h1, 10'd0);
  endtask

  task automatic test_full_table();
    write_size(2);
    send_item(lprh_pkg::OP_INSERT, 64'h40, 10'd10);
    send_item(lprh_pkg::OP_INSERT, 64'h40, 10'd11);
    send_item(lprh_pkg::OP_INSERT, 64'h80, 10'd12);
    send_item(lprh_pkg::OP_LOOKUP, 64'h80, 10'd0);
    send_item(lprh_pkg::OP_DELETE, 64'h40, 10'd10);
    send_item(lprh_pkg::OP_LOOKUP, 64'h40, 10'd0);
    send_item(lprh_pkg::OP_DELETE, 64'h40, 10'd11);
  endtask

  task automatic test_random(int unsigned size, int count);
    int pick, k;
    logic [lprh_pkg::KeyW-1:0] key;
    logic [lprh_pkg::IdxW-1:0] idx;
    write_size(size);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (live_idx.size() > size) pick = 75;
      if (pick < 40) begin
        key = near_key();
        idx = lprh_pkg::IdxW'($urandom_range(1, 1023));
        send_item(lprh_pkg::OP_INSERT, key, idx);
        if (!expected_rsps[$].error) begin
          live_keys.push_back(key);
          live_idx.push_back(idx);
        end
      end else if (pick < 70) begin
        k = live_idx.size() == 0 ? -1 : $urandom_range(0, live_idx.size() - 1);
        send_item(lprh_pkg::OP_LOOKUP, (k < 0 || pick < 48) ? near_key() : live_keys[k],
                  lprh_pkg::IdxW'($urandom));
      end else if (pick < 95) begin
        if (live_idx.size() == 0 || pick > 92) begin
          send_item(lprh_pkg::OP_DELETE, near_key(),
                    lprh_pkg::IdxW'($urandom_range(1, 1023)));
        end else begin
          k = $urandom_range(0, live_idx.size() - 1);
          send_item(lprh_pkg::OP_DELETE, live_keys[k], live_idx[k]);
          live_keys.delete(k);
          live_idx.delete(k);
        end
      end else begin
        send_item(lprh_pkg::opcode_e'($urandom_range(0, 3)),
                  $urandom_range(0, 1) ? 64'h0 : {$urandom, $urandom},
                  $urandom_range(0, 1) ? 10'd0 : lprh_pkg::IdxW'($urandom));
      end
    end
    no_gaps = 0;
  endtask

  task automatic test_backpressure();
    write_size(16);
    hold_off = 400;
    for (int i = 0; i < 20; i++) begin
      send_item(lprh_pkg::OP_INSERT, near_key(), lprh_pkg::IdxW'($urandom_range(1, 1023)));
    end
  endtask

  initial begin
    foreach (slot_mem[i]) slot_mem[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_full_table();
    test_backpressure();
    test_random(3, 200);
    test_random(8, 250);
    test_random(1024, 250);
    test_random(33, 250);
    test_random(2, 150);
    test_random(64, 250);
    test_random(13, 250);
    test_random(1024, 300);
    drain();
    repeat (200) @(posedge clk_i);
    $display("Covered %0d items over %0d table size settings, %0d results checked.",
             n_sent, n_sizes, n_checked);
    $display("Lookups, inserts into full tables, back-shift deletes and bad requests were mixed.");
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("** linear_probe_reverse_hash: PASSED **");
    end else begin
      $display("** linear_probe_reverse_hash: FAILED **");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("Timeout with %0d results outstanding.", expected_rsps.size());
    $display("** linear_probe_reverse_hash: FAILED **");
    $finish;
  end
endmodule
